@@ rtl/msto_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msto_pkg: shared types and constants of the timeout slot table
// Word layouts, command and result codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package msto_pkg;

  localparam int unsigned DefSlots    = 8;
  localparam int unsigned DefTimeBits = 16;
  localparam int unsigned MaxResults  = 8;
  localparam int unsigned QuantW      = 8;
  localparam int unsigned TagW        = 8;
  localparam logic [QuantW-1:0] QuantRst = 8'd10;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_STOP    = 3'd1,
    OP_DISABLE = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_CREATED = 3'd1,
    KIND_DUP     = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_SHORT   = 3'd4,
    KIND_EXPIRED = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [2:0]      slot;
    logic [15:0]     timeout_ms;
    logic [TagW-1:0] owner_tag;
    logic            repeat_req;
  } in_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [2:0]      slot_out;
    logic [TagW-1:0] tag_out;
    logic            last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;
    logic  div_start;
    logic  create_step;
    logic  create_wr;
    logic  tick_step;
    logic  flag_op;
    logic  push;
    kind_e push_kind;
  } msto_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic too_short;
    logic walk_last;
    logic div_done;
    logic dup;
    logic free_found;
    logic exp_hit;
    logic pend_valid;
  } msto_stat_t;

endpackage
`default_nettype wire

@@ rtl/multi_slot_timeout_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_timeout_table_core: table of one-shot and periodic timeout slots
// Create, stop, disable, enable and tick commands; expiry words out.
// ----------------------------------------------------------------------------
// Input words arrive on a valid/ready channel, one command each. Result words
// leave on a valid/ready channel; every command gives at least one, and the
// final one carries last. A tick gives one expired word per enabled slot that
// reached its limit (at most 8), or a single done word.
// The quantum register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, as the block does not enforce this.
// A tick walks the slots (RAM read, then evaluate, per slot); so does a create
// that is not too short, which also runs the bit-serial remainder that rounds
// the timeout down to a multiple of the quantum.
// A finished word waits in the output register; the next command is taken
// while it waits. Apart from a create waiting on the remainder, the block only
// pauses when it must place a further word. Reset clears all slot flags at
// once (no clearing pass) and loads a quantum of 10 ms.
module multi_slot_timeout_table_core
  import msto_pkg::*;
#(
  parameter int unsigned SLOTS     = DefSlots,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [QuantW-1:0] cfg_wdata_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output out_t              out_data_o
);

  msto_cmd_t  cmd;
  msto_stat_t stat;

  msto_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msto_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

@@ rtl/msto_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msto_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msto_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire  [AddrW-1:0]       waddr_i,
  input  wire  [Width-1:0]       wdata_i,
  input  wire  [AddrW-1:0]       raddr_i,
  output logic [Width-1:0]       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/msto_rem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msto_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; gives dividend mod divisor.
// ----------------------------------------------------------------------------
module msto_rem
  import msto_pkg::*;
#(
  parameter int unsigned Width = DefTimeBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire  [Width-1:0]   dividend_i,
  input  wire  [QuantW-1:0]  divisor_i,
  output logic               done_o,
  output logic [QuantW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [Width-1:0]  shf_q;
  logic [QuantW-1:0] rem_q, div_q;
  logic [QuantW:0]   trial;
  logic [QuantW:0]   trial_sub;
  logic [QuantW-1:0] rem_d;

  always_comb begin
    trial     = {rem_q, shf_q[Width-1]};
    trial_sub = trial - {1'b0, div_q};
    // remainder stays below the divisor, so eight bits always hold it
    rem_d     = (trial >= {1'b0, div_q}) ? trial_sub[QuantW-1:0] : trial[QuantW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Width);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shf_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      shf_q <= {shf_q[Width-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ rtl/msto_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msto_ctrl: sequencer of the timeout slot table
// Decodes each accepted word and walks the slots through the datapath.
// ----------------------------------------------------------------------------
module msto_ctrl
  import msto_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire  [2:0]  in_cmd_i,
  output logic        in_ready_o,
  input  msto_stat_t  stat_i,
  output msto_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CR_RD,
    ST_CR_EV,
    ST_CR_DEC,
    ST_SHORT,
    ST_FLAG,
    ST_TK_RD,
    ST_TK_EV,
    ST_TK_END
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.push_kind = KIND_DONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (in_cmd_i)
            OP_CREATE: state_d = ST_CHECK;
            OP_TICK:   state_d = ST_TK_RD;
            default:   state_d = ST_FLAG;
          endcase
        end
      end
      ST_CHECK: begin
        if (stat_i.too_short) begin
          state_d = ST_SHORT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_CR_RD;
        end
      end
      ST_CR_RD: state_d = ST_CR_EV;
      ST_CR_EV: begin
        cmd_o.create_step = 1'b1;
        state_d = stat_i.walk_last ? ST_CR_DEC : ST_CR_RD;
      end
      ST_CR_DEC: begin
        if (stat_i.dup) begin
          if (stat_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = KIND_DUP;
            state_d         = ST_IDLE;
          end
        end else if (!stat_i.free_found) begin
          if (stat_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_kind = KIND_FULL;
            state_d         = ST_IDLE;
          end
        end else if (stat_i.div_done && stat_i.out_free) begin
          cmd_o.create_wr = 1'b1;
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_CREATED;
          state_d         = ST_IDLE;
        end
      end
      ST_SHORT: begin
        if (stat_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_SHORT;
          state_d         = ST_IDLE;
        end
      end
      ST_FLAG: begin
        if (stat_i.out_free) begin
          cmd_o.flag_op   = 1'b1;
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = KIND_DONE;
          state_d         = ST_IDLE;
        end
      end
      ST_TK_RD: state_d = ST_TK_EV;
      ST_TK_EV: begin
        // a second expiry forces the held one out, so wait for room
        if (!(stat_i.exp_hit && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.tick_step = 1'b1;
          state_d = stat_i.walk_last ? ST_TK_END : ST_TK_RD;
        end
      end
      ST_TK_END: begin
        if (stat_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_kind = stat_i.pend_valid ? KIND_EXPIRED : KIND_DONE;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

@@ rtl/msto_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msto_dp: datapath of the timeout slot table
// Slot flags, slot RAM, walk index, remainder unit and the output register.
// ----------------------------------------------------------------------------
module msto_dp
  import msto_pkg::*;
#(
  parameter int unsigned SLOTS     = DefSlots,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [QuantW-1:0] cfg_wdata_i,
  input  in_t               in_data_i,
  input  wire               out_ready_i,
  output logic              out_valid_o,
  output out_t              out_data_o,
  input  msto_cmd_t         cmd_i,
  output msto_stat_t        stat_o
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EntW  = TagW + 2 * TIME_BITS;
  localparam int unsigned NumW  = $clog2(MaxResults + 1);
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  logic [QuantW-1:0]    quant_q;
  in_t                  item_q;
  logic [TIME_BITS-1:0] t_q;
  logic [SlotW:0]       idx_q;
  logic [SLOTS-1:0]     live_q, en_q, per_q;
  logic                 dup_q, free_q, pend_q;
  logic [SlotW-1:0]     free_idx_q, pend_idx_q;
  logic [TagW-1:0]      pend_tag_q;
  logic [NumW-1:0]      n_q;
  logic                 out_valid_q;
  out_t                 out_q, out_d;

  logic [QuantW-1:0]    q_eff;
  logic [31:0]          t_wide;
  logic [TIME_BITS-1:0] t_sat;
  logic [SlotW-1:0]     idx;
  logic [SlotW-1:0]     flag_idx;
  logic                 in_range;
  logic                 out_free;

  logic [EntW-1:0]      rd_data, wr_data;
  logic [TagW-1:0]      rd_tag;
  logic [TIME_BITS-1:0] rd_lim, rd_cnt;
  logic [TIME_BITS:0]   sum;
  logic                 below, reach, exp_hit;
  logic [TIME_BITS-1:0] sat_cnt, new_cnt, limit;
  logic                 ram_we;
  logic [SlotW-1:0]     ram_waddr;
  logic                 mid_push;
  logic                 div_done;
  logic [QuantW-1:0]    rem;

  // a zero quantum counts as one
  assign q_eff  = (quant_q == '0) ? QuantW'(1) : quant_q;
  assign t_wide = 32'(in_data_i.timeout_ms);
  assign t_sat  = (t_wide > 32'(TimeMax)) ? TimeMax : t_wide[TIME_BITS-1:0];

  assign idx      = idx_q[SlotW-1:0];
  assign flag_idx = SlotW'(item_q.slot);
  assign in_range = (32'(item_q.slot) < 32'(SLOTS));
  assign out_free = !out_valid_q || out_ready_i;

  assign rd_tag = rd_data[EntW-1 -: TagW];
  assign rd_lim = rd_data[2*TIME_BITS-1 -: TIME_BITS];
  assign rd_cnt = rd_data[TIME_BITS-1:0];

  // saturating tick update; reach is the post-update count >= limit
  always_comb begin
    sum     = {1'b0, rd_cnt} + (TIME_BITS+1)'(q_eff);
    below   = rd_cnt < rd_lim;
    reach   = !below || (sum >= {1'b0, rd_lim});
    sat_cnt = below ? ((sum > {1'b0, rd_lim}) ? rd_lim : sum[TIME_BITS-1:0]) : rd_cnt;
    exp_hit = live_q[idx] && en_q[idx] && reach && (n_q < NumW'(MaxResults));
    new_cnt = exp_hit ? '0 : sat_cnt;
  end

  assign limit     = t_q - TIME_BITS'(rem);
  assign ram_we    = cmd_i.create_wr || (cmd_i.tick_step && live_q[idx]);
  assign ram_waddr = cmd_i.create_wr ? free_idx_q : idx;
  assign wr_data   = cmd_i.create_wr ? {item_q.owner_tag, limit, {TIME_BITS{1'b0}}}
                                     : {rd_tag, rd_lim, new_cnt};

  msto_ram #(
    .Width (EntW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  msto_rem #(
    .Width (TIME_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (t_q),
    .divisor_i  (q_eff),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // earlier expiry of a tick leaves as soon as a later one turns up
  assign mid_push = cmd_i.tick_step && exp_hit && pend_q;

  always_comb begin
    out_d = '0;
    if (mid_push) begin
      out_d.kind     = KIND_EXPIRED;
      out_d.slot_out = 3'(pend_idx_q);
      out_d.tag_out  = pend_tag_q;
      out_d.last     = 1'b0;
    end else begin
      out_d.kind = cmd_i.push_kind;
      out_d.last = 1'b1;
      case (cmd_i.push_kind)
        KIND_CREATED: out_d.slot_out = 3'(free_idx_q);
        KIND_EXPIRED: begin
          out_d.slot_out = 3'(pend_idx_q);
          out_d.tag_out  = pend_tag_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q     <= QuantRst;
      idx_q       <= '0;
      live_q      <= '0;
      en_q        <= '0;
      per_q       <= '0;
      dup_q       <= 1'b0;
      free_q      <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quant_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q  <= '0;
        dup_q  <= 1'b0;
        free_q <= 1'b0;
        pend_q <= 1'b0;
        n_q    <= '0;
      end
      if (cmd_i.create_step) begin
        idx_q <= idx_q + (SlotW+1)'(1);
        if ((item_q.owner_tag != '0) && live_q[idx] && (rd_tag == item_q.owner_tag)) begin
          dup_q <= 1'b1;
        end
        if (!live_q[idx]) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.tick_step) begin
        idx_q <= idx_q + (SlotW+1)'(1);
        if (exp_hit) begin
          pend_q <= 1'b1;
          n_q    <= n_q + NumW'(1);
          if (!per_q[idx]) begin
            live_q[idx] <= 1'b0;
          end
        end
      end
      if (cmd_i.flag_op && in_range) begin
        case (item_q.cmd)
          OP_STOP:    live_q[flag_idx] <= 1'b0;
          OP_DISABLE: en_q[flag_idx]   <= 1'b0;
          OP_ENABLE:  en_q[flag_idx]   <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.create_wr) begin
        live_q[free_idx_q] <= 1'b1;
        en_q[free_idx_q]   <= 1'b1;
        per_q[free_idx_q]  <= item_q.repeat_req;
      end
      if (cmd_i.push || mid_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      t_q    <= t_sat;
    end
    if (cmd_i.create_step && !live_q[idx] && !free_q) begin
      free_idx_q <= idx;
    end
    if (cmd_i.tick_step && exp_hit) begin
      pend_idx_q <= idx;
      pend_tag_q <= rd_tag;
    end
    if (cmd_i.push || mid_push) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    stat_o            = '0;
    stat_o.out_free   = out_free;
    stat_o.too_short  = t_q < TIME_BITS'(q_eff);
    stat_o.walk_last  = (idx_q == (SlotW+1)'(SLOTS - 1));
    stat_o.div_done   = div_done;
    stat_o.dup        = dup_q;
    stat_o.free_found = free_q;
    stat_o.exp_hit    = exp_hit;
    stat_o.pend_valid = pend_q;
  end

endmodule
`default_nettype wire
